// File: rtl/bfrl_pkg.sv
// shared types and constants for the run-length token coalescer
`default_nettype none

package bfrl_pkg;

  // loop nesting limit and the counter width it needs
  localparam int MAX_DEPTH = 4096;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

  // result queue geometry
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // source command bytes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  // input mode codes
  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_END  = 1'b1;

  typedef enum logic [2:0] {
    KIND_ADD   = 3'd0,
    KIND_MOVE  = 3'd1,
    KIND_OUT   = 3'd2,
    KIND_IN    = 3'd3,
    KIND_OPEN  = 3'd4,
    KIND_CLOSE = 3'd5,
    KIND_END   = 3'd6,
    KIND_ERR   = 3'd7
  } tok_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNMATCHED = 2'd1,
    ERR_UNCLOSED  = 2'd2,
    ERR_OVERFLOW  = 2'd3
  } err_code_t;

  typedef struct packed {
    tok_kind_t          kind;
    logic signed [15:0] amount;
    err_code_t          err;
    logic               last;
  } token_t;

  // up to two tokens produced by one beat
  typedef struct packed {
    logic [1:0] n;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  typedef struct packed {
    logic signed [15:0]   value_run;
    logic signed [15:0]   move_run;
    logic [DEPTH_W-1:0]   loop_depth;
    logic                 failed;
  } run_state_t;

endpackage

`default_nettype wire

// File: rtl/bfrl_step.sv
// combinational step: one command beat against the run state
`default_nettype none

module bfrl_step (
  input  bfrl_pkg::run_state_t st,
  input  logic                 mode,
  input  logic [7:0]           char_code,
  output bfrl_pkg::push_t      push,
  output bfrl_pkg::run_state_t st_nxt
);
  import bfrl_pkg::*;

  localparam logic signed [15:0] RUN_MAX = 16'sh7FFF;
  localparam logic signed [15:0] RUN_MIN = 16'sh8000;

  // saturating +/-1 on a run total
  function automatic logic signed [15:0] run_step(logic signed [15:0] acc, logic up);
    logic signed [15:0] r;
    if (up) begin
      r = (acc == RUN_MAX) ? acc : acc + 16'sd1;
    end else begin
      r = (acc == RUN_MIN) ? acc : acc - 16'sd1;
    end
    return r;
  endfunction

  function automatic token_t mk_tok(tok_kind_t k, logic signed [15:0] a, err_code_t e);
    token_t t;
    t.kind   = k;
    t.amount = a;
    t.err    = e;
    t.last   = 1'b0;
    return t;
  endfunction

  logic   fl_v;
  token_t fl_tok;
  logic   pre_v;
  logic   main_v;
  token_t pre_tok;
  token_t main_tok;

  // pending run flush token
  always_comb begin
    fl_v   = (st.value_run != 16'sd0) || (st.move_run != 16'sd0);
    fl_tok = (st.value_run != 16'sd0) ? mk_tok(KIND_ADD, st.value_run, ERR_NONE)
                                      : mk_tok(KIND_MOVE, st.move_run, ERR_NONE);
  end

  // command decode and state update
  always_comb begin
    pre_v    = 1'b0;
    main_v   = 1'b0;
    pre_tok  = fl_tok;
    main_tok = mk_tok(KIND_END, 16'sd0, ERR_NONE);
    st_nxt   = st;
    if (mode == MODE_END) begin
      main_v = 1'b1;
      if (!st.failed) begin
        pre_v = fl_v;
        if (st.loop_depth != '0) begin
          main_tok = mk_tok(KIND_ERR, 16'sd0, ERR_UNCLOSED);
        end
      end
      st_nxt = '0;
    end else if (!st.failed) begin
      case (char_code)
        CH_PLUS, CH_MINUS: begin
          if (st.move_run != 16'sd0) begin
            pre_v   = 1'b1;
            pre_tok = mk_tok(KIND_MOVE, st.move_run, ERR_NONE);
          end
          st_nxt.move_run  = 16'sd0;
          st_nxt.value_run = run_step(st.value_run, char_code == CH_PLUS);
        end
        CH_RIGHT, CH_LEFT: begin
          if (st.value_run != 16'sd0) begin
            pre_v   = 1'b1;
            pre_tok = mk_tok(KIND_ADD, st.value_run, ERR_NONE);
          end
          st_nxt.value_run = 16'sd0;
          st_nxt.move_run  = run_step(st.move_run, char_code == CH_RIGHT);
        end
        CH_DOT, CH_COMMA: begin
          pre_v            = fl_v;
          main_v           = 1'b1;
          main_tok         = mk_tok((char_code == CH_DOT) ? KIND_OUT : KIND_IN, 16'sd0,
                                    ERR_NONE);
          st_nxt.value_run = 16'sd0;
          st_nxt.move_run  = 16'sd0;
        end
        CH_OPEN: begin
          main_v           = 1'b1;
          st_nxt.value_run = 16'sd0;
          st_nxt.move_run  = 16'sd0;
          if (st.loop_depth >= DEPTH_W'(MAX_DEPTH)) begin
            main_tok      = mk_tok(KIND_ERR, 16'sd0, ERR_OVERFLOW);
            st_nxt.failed = 1'b1;
          end else begin
            pre_v             = fl_v;
            main_tok          = mk_tok(KIND_OPEN, 16'sd0, ERR_NONE);
            st_nxt.loop_depth = st.loop_depth + DEPTH_W'(1);
          end
        end
        CH_CLOSE: begin
          main_v           = 1'b1;
          st_nxt.value_run = 16'sd0;
          st_nxt.move_run  = 16'sd0;
          if (st.loop_depth == '0) begin
            main_tok      = mk_tok(KIND_ERR, 16'sd0, ERR_UNMATCHED);
            st_nxt.failed = 1'b1;
          end else begin
            pre_v             = fl_v;
            main_tok          = mk_tok(KIND_CLOSE, 16'sd0, ERR_NONE);
            st_nxt.loop_depth = st.loop_depth - DEPTH_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // order tokens: flushed run first, then the command token
  always_comb begin
    push.n         = {1'b0, pre_v} + {1'b0, main_v};
    push.tok0      = pre_v ? pre_tok : main_tok;
    push.tok0.last = !(pre_v && main_v);
    push.tok1      = main_tok;
    push.tok1.last = 1'b1;
  end

endmodule

`default_nettype wire

// File: rtl/bfrl_outq.sv
// small result queue: up to two pushes and one pop per cycle
`default_nettype none

module bfrl_outq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bfrl_pkg::push_t             push,
  input  logic                        pop,
  output bfrl_pkg::token_t            head,
  output logic [bfrl_pkg::OQ_CW-1:0]  cnt
);
  import bfrl_pkg::*;

  token_t           mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r;
  logic [OQ_AW-1:0] wr_ptr_nxt;
  logic [OQ_AW-1:0] rd_ptr_r;
  logic [OQ_AW-1:0] rd_ptr_nxt;
  logic [OQ_CW-1:0] cnt_r;
  logic [OQ_CW-1:0] cnt_nxt;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OQ_AW'(push.n);
    rd_ptr_nxt = rd_ptr_r + OQ_AW'(pop);
    cnt_nxt    = cnt_r + OQ_CW'(push.n) - OQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // token storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.tok0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_r + OQ_AW'(1)] <= push.tok1;
    end
  end

  assign head = mem_r[rd_ptr_r];
  assign cnt  = cnt_r;

endmodule

`default_nettype wire

// File: rtl/bf_run_length_token_coalescer.sv
// top level: input register, run state, step logic and result queue
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | mode, char_code
//  out_    | output    | out_valid/out_stall | token_kind, amount, error_code, last
//
// A beat waits in the input register and is decoded into zero to two tokens
// that land in a four-entry result queue; the first token shows on out_ once
// the queue has registered it. One beat per cycle is sustained while beats give
// at most one token and out_stall is low; the single output port slows two-token
// beats. in_stall rises when the queue holds fewer than two free entries.
// Synchronous active-low reset empties the queue and clears the run state.
`default_nettype none

module bf_run_length_token_coalescer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [7:0]         in_char_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_token_kind,
  output logic signed [15:0] out_amount,
  output logic [1:0]         out_error_code,
  output logic               out_last
);
  import bfrl_pkg::*;

  logic             in_vld_r;
  logic             in_vld_nxt;
  logic             mode_r;
  logic [7:0]       char_r;
  logic             in_acc;
  logic             proc;
  logic             pop;
  run_state_t       st_r;
  run_state_t       st_nxt;
  push_t            step_push;
  push_t            q_push;
  token_t           head;
  logic [OQ_CW-1:0] q_cnt;

  // handshake and processing enables
  always_comb begin
    proc       = in_vld_r && (q_cnt <= OQ_CW'(OQ_DEPTH - 2));
    in_stall   = in_vld_r && !proc;
    in_acc     = in_valid && !in_stall;
    in_vld_nxt = in_acc || (in_vld_r && !proc);
    pop        = (q_cnt != '0) && !out_stall;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_mode;
      char_r <= in_char_code;
    end
  end

  // run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (proc) begin
      st_r <= st_nxt;
    end
  end

  bfrl_step u_step (
    .st        (st_r),
    .mode      (mode_r),
    .char_code (char_r),
    .push      (step_push),
    .st_nxt    (st_nxt)
  );

  // only push while the beat is actually consumed
  always_comb begin
    q_push   = step_push;
    q_push.n = proc ? step_push.n : 2'd0;
  end

  bfrl_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (pop),
    .head  (head),
    .cnt   (q_cnt)
  );

  // result port
  assign out_valid      = (q_cnt != '0);
  assign out_token_kind = head.kind;
  assign out_amount     = head.amount;
  assign out_error_code = head.err;
  assign out_last       = head.last;

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= OQ_CW'(OQ_DEPTH))
    else $error("result queue overfilled");

  a_one_run: assert property (@(posedge clk) disable iff (!rst_n)
    !((st_r.value_run != 16'sd0) && (st_r.move_run != 16'sd0)))
    else $error("both run totals pending");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.loop_depth <= DEPTH_W'(MAX_DEPTH))
    else $error("loop depth beyond limit");

  a_failed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.failed |-> ((st_r.value_run == 16'sd0) && (st_r.move_run == 16'sd0)))
    else $error("run pending after error");
`endif

endmodule

`default_nettype wire

// File: verif/tb.sv
// testbench for the run-length token coalescer: directed commands and random programs
`timescale 1ns / 1ps

module tb;
  import bfrl_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_BEATS = 900;
  localparam int SETTLE_CYCLES = 20;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_mode = MODE_CHAR;
  logic [7:0]         in_char_code = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_token_kind;
  logic signed [15:0] out_amount;
  logic [1:0]         out_error_code;
  logic               out_last;

  bf_run_length_token_coalescer uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_char_code  (in_char_code),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_token_kind(out_token_kind),
    .out_amount    (out_amount),
    .out_error_code(out_error_code),
    .out_last      (out_last)
  );

  // shadow run state of the coalescer
  logic signed [15:0] val_acc = '0;
  logic signed [15:0] move_acc = '0;
  int unsigned        open_depth = 0;
  bit                 halted = 1'b0;

  // tokens still owed by the block, oldest first
  token_t pending_tokens[$];

  int errors = 0;
  int cycles = 0;
  int beats_sent = 0;
  int tokens_checked = 0;
  int error_tokens = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side back-pressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each accepted token with the oldest owed one
  always @(posedge clk) begin
    token_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_tokens.size() == 0) begin
        $error("unexpected token: kind %0d amount %0d error_code %0d last %0d",
               out_token_kind, out_amount, out_error_code, out_last);
        errors++;
      end else begin
        want = pending_tokens.pop_front();
        tokens_checked++;
        if (want.kind == KIND_ERR) error_tokens++;
        if (out_token_kind !== want.kind) begin
          $error("token_kind: expected %0d, actual %0d", want.kind, out_token_kind);
          errors++;
        end
        if (out_amount !== want.amount) begin
          $error("amount: expected %0d, actual %0d", want.amount, out_amount);
          errors++;
        end
        if (out_error_code !== want.err) begin
          $error("error_code: expected %0d, actual %0d", want.err, out_error_code);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_last);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [15:0] sat_step(input logic signed [15:0] acc, input int delta);
    int r;
    r = acc + delta;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic void push_token(input tok_kind_t k, input logic signed [15:0] amt,
                                     input err_code_t code);
    token_t t;
    t.kind   = k;
    t.amount = amt;
    t.err    = code;
    t.last   = 1'b0;
    pending_tokens.push_back(t);
  endfunction

  // emit whichever run is pending and clear both
  function automatic void flush_runs();
    if (val_acc != 0) push_token(KIND_ADD, val_acc, ERR_NONE);
    if (move_acc != 0) push_token(KIND_MOVE, move_acc, ERR_NONE);
    val_acc  = '0;
    move_acc = '0;
  endfunction

  function automatic void raise_error(input err_code_t code);
    val_acc  = '0;
    move_acc = '0;
    halted   = 1'b1;
    push_token(KIND_ERR, '0, code);
  endfunction

  // work out the tokens one accepted beat causes
  function automatic void predict_tokens(input logic mode, input logic [7:0] ch);
    int     before_n;
    token_t t;
    before_n = pending_tokens.size();
    if (mode == MODE_END) begin
      if (halted) begin
        push_token(KIND_END, '0, ERR_NONE);
      end else begin
        flush_runs();
        if (open_depth != 0) push_token(KIND_ERR, '0, ERR_UNCLOSED);
        else push_token(KIND_END, '0, ERR_NONE);
      end
      val_acc    = '0;
      move_acc   = '0;
      open_depth = 0;
      halted     = 1'b0;
    end else if (!halted) begin
      case (ch)
        CH_PLUS, CH_MINUS: begin
          if (move_acc != 0) begin
            push_token(KIND_MOVE, move_acc, ERR_NONE);
            move_acc = '0;
          end
          val_acc = sat_step(val_acc, (ch == CH_PLUS) ? 1 : -1);
        end
        CH_RIGHT, CH_LEFT: begin
          if (val_acc != 0) begin
            push_token(KIND_ADD, val_acc, ERR_NONE);
            val_acc = '0;
          end
          move_acc = sat_step(move_acc, (ch == CH_RIGHT) ? 1 : -1);
        end
        CH_DOT: begin
          flush_runs();
          push_token(KIND_OUT, '0, ERR_NONE);
        end
        CH_COMMA: begin
          flush_runs();
          push_token(KIND_IN, '0, ERR_NONE);
        end
        CH_OPEN: begin
          if (open_depth >= MAX_DEPTH) begin
            raise_error(ERR_OVERFLOW);
          end else begin
            open_depth++;
            flush_runs();
            push_token(KIND_OPEN, '0, ERR_NONE);
          end
        end
        CH_CLOSE: begin
          if (open_depth == 0) begin
            raise_error(ERR_UNMATCHED);
          end else begin
            open_depth--;
            flush_runs();
            push_token(KIND_CLOSE, '0, ERR_NONE);
          end
        end
        default: ;
      endcase
    end
    // mark the final token of this beat
    if (pending_tokens.size() > before_n) begin
      t = pending_tokens.pop_back();
      t.last = 1'b1;
      pending_tokens.push_back(t);
    end
  endfunction

  // sender idle length: mostly none or short, a few long
  function automatic int pick_gap();
    if (gap_pct == 0 || $urandom_range(0, 99) >= gap_pct) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
  endfunction

  // drive one beat and wait for it to be taken
  task automatic send_beat(input logic mode, input logic [7:0] ch);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_char_code <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tokens(mode, ch);
    beats_sent++;
  endtask

  task automatic send_run(input logic [7:0] ch, input int count);
    repeat (count) send_beat(MODE_CHAR, ch);
  endtask

  // wait for every owed token, then a little longer for strays
  task automatic drain_tokens();
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // every command, zero-net runs, ignored bytes and the unclosed and unmatched error paths
  task automatic test_directed();
    gap_pct   = 30;
    stall_pct = 30;
    send_beat(MODE_END, 8'h00);
    send_run(CH_PLUS, 3);
    send_run(CH_RIGHT, 2);
    send_run(CH_LEFT, 3);
    send_beat(MODE_CHAR, CH_MINUS);
    send_beat(MODE_CHAR, CH_DOT);
    // run that nets to zero gives no token
    send_beat(MODE_CHAR, CH_PLUS);
    send_beat(MODE_CHAR, CH_MINUS);
    send_beat(MODE_CHAR, CH_COMMA);
    // non-command bytes
    send_beat(MODE_CHAR, 8'h61);
    send_beat(MODE_CHAR, 8'hFF);
    send_beat(MODE_CHAR, 8'h00);
    send_beat(MODE_CHAR, CH_OPEN);
    send_beat(MODE_CHAR, CH_CLOSE);
    // unclosed loop flushes the run, then reports
    send_beat(MODE_CHAR, CH_OPEN);
    send_beat(MODE_CHAR, CH_RIGHT);
    send_beat(MODE_END, 8'hFF);
    // unmatched close, then ignored until the end beat
    send_beat(MODE_CHAR, CH_PLUS);
    send_beat(MODE_CHAR, CH_CLOSE);
    send_beat(MODE_CHAR, CH_DOT);
    send_beat(MODE_END, 8'h5A);
  endtask

  // mostly balanced programs with random content, some broken ones and noise
  task automatic test_random_programs();
    int         counted;
    int         open_loops;
    int         len;
    int         pick;
    int         run;
    int         k;
    bit         broken;
    bit         bias;
    logic [7:0] ch;
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      // vary pressure per program, sometimes none at all
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 20;
        default: gap_pct = 60;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 25;
        default: stall_pct = 60;
      endcase
      broken     = ($urandom_range(0, 4) == 0);
      open_loops = 0;
      len        = $urandom_range(4, 40);
      for (k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          // add or move run with a mostly one-way direction
          run  = $urandom_range(1, 6);
          bias = 1'($urandom_range(0, 1));
          repeat (run) begin
            if (pick < 28)
              ch = (($urandom_range(0, 3) == 0) ^ bias) ? CH_MINUS : CH_PLUS;
            else
              ch = (($urandom_range(0, 3) == 0) ^ bias) ? CH_LEFT : CH_RIGHT;
            send_beat(MODE_CHAR, ch);
          end
          counted += run;
        end else if (pick < 58) begin
          send_beat(MODE_CHAR, CH_DOT);
          counted++;
        end else if (pick < 64) begin
          send_beat(MODE_CHAR, CH_COMMA);
          counted++;
        end else if (pick < 76) begin
          send_beat(MODE_CHAR, CH_OPEN);
          open_loops++;
          counted++;
        end else if (pick < 88) begin
          if (open_loops > 0 || broken) begin
            send_beat(MODE_CHAR, CH_CLOSE);
            if (open_loops > 0) open_loops--;
            counted++;
          end
        end else begin
          send_beat(MODE_CHAR, 8'($urandom_range(0, 255)));
          counted++;
        end
      end
      if (!broken) begin
        send_run(CH_CLOSE, open_loops);
        counted += open_loops;
      end
      send_beat(MODE_END, 8'($urandom_range(0, 255)));
      counted++;
    end
  endtask

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_programs();
    in_valid <= 1'b0;
    stall_pct = 0;
    drain_tokens();
    $display("covered %0d source beats and %0d tokens, %0d of them error tokens",
             beats_sent, tokens_checked, error_tokens);
    $display("directed commands and error paths, then random programs under back-pressure");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
